// ===== design/cqm_pkg.sv =====
package cqm_pkg;

  localparam int DefActDepth      = 4096;
  localparam int DefWeightDepth   = 4096;
  localparam int DefMaxOutChannels = 64;

  localparam int CfgW = 9;

  typedef enum logic [1:0] {
    OP_LOAD_ACT = 2'd0,
    OP_LOAD_W   = 2'd1,
    OP_LOAD_WZP = 2'd2,
    OP_COMPUTE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_IMAGE_HEIGHT   = 3'd0,
    REG_IMAGE_WIDTH    = 3'd1,
    REG_CHANNELS       = 3'd2,
    REG_KERNEL_HEIGHT  = 3'd3,
    REG_KERNEL_WIDTH   = 3'd4,
    REG_DILATION_ROWS  = 3'd5,
    REG_DILATION_COLS  = 3'd6,
    REG_INPUT_ZP       = 3'd7
  } reg_e;

  typedef logic signed [35:0] wide_t;

  typedef struct packed {
    logic [8:0]        image_height;
    logic [8:0]        image_width;
    logic [8:0]        channels_per_group;
    logic [4:0]        kernel_height;
    logic [4:0]        kernel_width;
    logic [4:0]        dilation_rows;
    logic [4:0]        dilation_cols;
    logic signed [8:0] input_zero_point;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic              wr_ok;
    logic [11:0]       store_address;
    logic signed [8:0] load_value;
    logic [5:0]        out_channel;
    logic [5:0]        group_index;
    logic signed [8:0] origin_row;
    logic signed [8:0] origin_col;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ===== design/cqm_ram.sv =====
module cqm_ram #(
  parameter int Width = 9,
  parameter int Depth = 64,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/cqm_front.sv =====
module cqm_front import cqm_pkg::*; #(
  parameter int ActDepth       = DefActDepth,
  parameter int WeightDepth    = DefWeightDepth,
  parameter int MaxOutChannels = DefMaxOutChannels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        op_i,
  input  logic [11:0]       store_address_i,
  input  logic signed [8:0] load_value_i,
  input  logic [5:0]        out_channel_i,
  input  logic [5:0]        group_index_i,
  input  logic signed [8:0] origin_row_i,
  input  logic signed [8:0] origin_col_i,
  input  logic              pop_i,
  output head_t             head_o
);

  item_t      q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      in_item;
  logic [20:0] addr_ext;

  // classify: does a load land inside its store
  assign addr_ext = 21'(store_address_i);

  always_comb begin
    in_item.op            = op_e'(op_i);
    in_item.store_address = store_address_i;
    in_item.load_value    = load_value_i;
    in_item.out_channel   = out_channel_i;
    in_item.group_index   = group_index_i;
    in_item.origin_row    = origin_row_i;
    in_item.origin_col    = origin_col_i;
    unique case (op_e'(op_i))
      OP_LOAD_ACT: in_item.wr_ok = addr_ext < 21'(ActDepth);
      OP_LOAD_W:   in_item.wr_ok = addr_ext < 21'(WeightDepth);
      OP_LOAD_WZP: in_item.wr_ok = addr_ext < 21'(MaxOutChannels);
      default:     in_item.wr_ok = 1'b0;
    endcase
  end

  assign busy_o      = cnt_q[1];
  assign push        = start_i && !busy_o;
  assign pop         = pop_i && (cnt_q != 2'd0);
  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.item  = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/cqm_back.sv =====
module cqm_back import cqm_pkg::*; #(
  parameter int ActDepth       = DefActDepth,
  parameter int WeightDepth    = DefWeightDepth,
  parameter int MaxOutChannels = DefMaxOutChannels,
  localparam int ActAw = (ActDepth > 1) ? $clog2(ActDepth) : 1,
  localparam int WAw   = (WeightDepth > 1) ? $clog2(WeightDepth) : 1,
  localparam int ZAw   = (MaxOutChannels > 1) ? $clog2(MaxOutChannels) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  head_t              head_i,
  output logic               pop_o,
  output logic               done_o,
  output logic signed [31:0] conv_sum_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_RUN, S_DRAIN
  } state_e;

  state_e            state_q;
  item_t             it_q;
  logic [14:0]       base_q;
  logic [24:0]       wb_q;
  logic [17:0]       hw_q;
  logic signed [18:0] orw_q;
  logic [13:0]       drw_q;
  wide_t             row0_q, rc_q;
  logic [24:0]       waddr_q;
  logic signed [12:0] row_q, col_q;
  logic [8:0]        c_q;
  logic [4:0]        kh_q, kw_q;
  logic signed [8:0] wzp_q;
  logic              v1_q, v2_q;
  logic signed [19:0] prod_q;
  logic [31:0]       acc_q;
  logic [1:0]        dcnt_q;
  logic              done_q;
  logic [31:0]       sum_q;

  // memories
  logic              act_we, w_we, z_we;
  logic [ActAw-1:0]  act_raddr;
  logic [WAw-1:0]    w_raddr;
  logic [8:0]        act_rd, w_rd, z_rd;
  item_t             hd;

  assign hd     = head_i.item;
  assign pop_o  = (state_q == S_IDLE) && head_i.valid;
  assign act_we = pop_o && hd.op == OP_LOAD_ACT && hd.wr_ok;
  assign w_we   = pop_o && hd.op == OP_LOAD_W && hd.wr_ok;
  assign z_we   = pop_o && hd.op == OP_LOAD_WZP && hd.wr_ok;

  // tap address and bounds
  wide_t tap_a;
  logic  row_ok, col_ok, tap_ok;
  assign tap_a  = rc_q + wide_t'(col_q);
  assign row_ok = (row_q >= 13'sd0) && (row_q < $signed({4'b0, cfg_i.image_height}));
  assign col_ok = (col_q >= 13'sd0) && (col_q < $signed({4'b0, cfg_i.image_width}));
  assign tap_ok = row_ok && col_ok && (tap_a < $signed(36'(ActDepth)))
                  && ({11'b0, waddr_q} < 36'(WeightDepth));
  assign act_raddr = tap_a[ActAw-1:0];
  assign w_raddr   = waddr_q[WAw-1:0];

  cqm_ram #(.Width(9), .Depth(ActDepth)) u_act (
    .clk_i, .we_i(act_we), .waddr_i(ActAw'(hd.store_address)),
    .wdata_i(hd.load_value), .raddr_i(act_raddr), .rdata_o(act_rd)
  );

  cqm_ram #(.Width(9), .Depth(WeightDepth)) u_wgt (
    .clk_i, .we_i(w_we), .waddr_i(WAw'(hd.store_address)),
    .wdata_i(hd.load_value), .raddr_i(w_raddr), .rdata_o(w_rd)
  );

  cqm_ram #(.Width(9), .Depth(MaxOutChannels)) u_wzp (
    .clk_i, .we_i(z_we), .waddr_i(ZAw'(hd.store_address)),
    .wdata_i(hd.load_value), .raddr_i(ZAw'(hd.out_channel)), .rdata_o(z_rd)
  );

  // setup products
  logic [14:0]       base_p, wb_p0;
  logic [17:0]       hw_p;
  logic signed [18:0] orw_p;
  logic [13:0]       drw_p;
  logic [32:0]       row0_p;
  logic [24:0]       wb_p1, wb_p2;
  assign base_p = 15'(it_q.group_index) * 15'(cfg_i.channels_per_group);
  assign wb_p0  = 15'(it_q.out_channel) * 15'(cfg_i.channels_per_group);
  assign hw_p   = 18'(cfg_i.image_height) * 18'(cfg_i.image_width);
  assign orw_p  = $signed({{10{it_q.origin_row[8]}}, it_q.origin_row})
                  * $signed({10'b0, cfg_i.image_width});
  assign drw_p  = 14'(cfg_i.dilation_rows) * 14'(cfg_i.image_width);
  assign row0_p = 33'(base_q) * 33'(hw_q);
  assign wb_p1  = wb_q * 25'(cfg_i.kernel_height);
  assign wb_p2  = wb_q * 25'(cfg_i.kernel_width);

  // data stage
  logic signed [9:0]  xv, wv;
  logic signed [19:0] prod_d;
  assign xv     = $signed({act_rd[8], act_rd}) - $signed({cfg_i.input_zero_point[8],
                                                          cfg_i.input_zero_point});
  assign wv     = $signed({w_rd[8], w_rd}) - $signed({wzp_q[8], wzp_q});
  assign prod_d = xv * wv;

  logic last_kw, last_kh, last_c;
  assign last_kw = kw_q == cfg_i.kernel_width - 5'd1;
  assign last_kh = kh_q == cfg_i.kernel_height - 5'd1;
  assign last_c  = c_q == cfg_i.channels_per_group - 9'd1;

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= hd;
    prod_q <= prod_d;
    sum_q  <= acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= '0;
      wb_q    <= '0;
      hw_q    <= '0;
      orw_q   <= '0;
      drw_q   <= '0;
      row0_q  <= '0;
      rc_q    <= '0;
      waddr_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      c_q     <= '0;
      kh_q    <= '0;
      kw_q    <= '0;
      wzp_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      acc_q   <= '0;
      dcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      v1_q   <= (state_q == S_RUN) && tap_ok;
      v2_q   <= v1_q;
      done_q <= (state_q == S_DRAIN) && (dcnt_q == 2'd2);
      if (state_q == S_M0) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + 32'(prod_q);
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o && hd.op == OP_COMPUTE) state_q <= S_M0;
        end
        S_M0: begin
          base_q <= base_p;
          wb_q   <= 25'(wb_p0);
          hw_q   <= hw_p;
          orw_q  <= orw_p;
          drw_q  <= drw_p;
          wzp_q  <= (13'(it_q.out_channel) < 13'(MaxOutChannels)) ? $signed(z_rd) : 9'sd0;
          state_q <= S_M1;
        end
        S_M1: begin
          row0_q  <= wide_t'(row0_p);
          wb_q    <= wb_p1;
          state_q <= S_M2;
        end
        S_M2: begin
          row0_q  <= row0_q + wide_t'(orw_q);
          rc_q    <= row0_q + wide_t'(orw_q);
          waddr_q <= wb_p2;
          row_q   <= 13'(it_q.origin_row);
          col_q   <= 13'(it_q.origin_col);
          c_q     <= '0;
          kh_q    <= '0;
          kw_q    <= '0;
          dcnt_q  <= '0;
          // empty kernel or channel set: nothing to accumulate
          if (cfg_i.channels_per_group == 9'd0 || cfg_i.kernel_height == 5'd0
              || cfg_i.kernel_width == 5'd0) begin
            state_q <= S_DRAIN;
          end else begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          waddr_q <= waddr_q + 25'd1;
          if (last_kw) begin
            kw_q  <= '0;
            col_q <= 13'(it_q.origin_col);
            if (last_kh) begin
              kh_q   <= '0;
              row_q  <= 13'(it_q.origin_row);
              c_q    <= c_q + 9'd1;
              rc_q   <= row0_q + wide_t'(hw_q);
              row0_q <= row0_q + wide_t'(hw_q);
              if (last_c) state_q <= S_DRAIN;
            end else begin
              kh_q  <= kh_q + 5'd1;
              row_q <= row_q + $signed({8'b0, cfg_i.dilation_rows});
              rc_q  <= rc_q + wide_t'(drw_q);
            end
          end else begin
            kw_q  <= kw_q + 5'd1;
            col_q <= col_q + $signed({8'b0, cfg_i.dilation_cols});
          end
        end
        S_DRAIN: begin
          // wait for the read and multiply stages to empty
          dcnt_q <= dcnt_q + 2'd1;
          if (dcnt_q == 2'd2) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o     = done_q;
  assign conv_sum_o = $signed(sum_q);

endmodule

// ===== design/quantized_conv2d_mac_core.sv =====
// channel  | ports                                        | handshake
// ---------+----------------------------------------------+------------------------
// input    | op_i store_address_i load_value_i            | start_i && !busy_o
//          | out_channel_i group_index_i origin_*_i       |
// result   | conv_sum_o                                   | done_o, one cycle
// config   | cfg_we_i cfg_idx_i cfg_wdata_i               | cfg_we_i, no wait
//
// a two-word queue sits between the input and the execution sequencer
// load: leaves the queue and writes its store if in range; no result
// compute: a dequeue step, setup states S_M0, S_M1 and S_M2, then S_RUN walks every
// channel and kernel tap (one tap per cycle through the activation and weight ram
// ports), S_DRAIN, then done_o for one cycle; busy_o is high while the queue is full
// reset clears control and loads config defaults; stores are undefined until loaded
module quantized_conv2d_mac_core import cqm_pkg::*; #(
  parameter int ActDepth       = DefActDepth,
  parameter int WeightDepth    = DefWeightDepth,
  parameter int MaxOutChannels = DefMaxOutChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic [11:0]        store_address_i,
  input  logic signed [8:0]  load_value_i,
  input  logic [5:0]         out_channel_i,
  input  logic [5:0]         group_index_i,
  input  logic signed [8:0]  origin_row_i,
  input  logic signed [8:0]  origin_col_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] conv_sum_o
);

  cfg_t  cfg_q;
  head_t head;
  logic  pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_height       <= 9'd1;
      cfg_q.image_width        <= 9'd1;
      cfg_q.channels_per_group <= 9'd1;
      cfg_q.kernel_height      <= 5'd1;
      cfg_q.kernel_width       <= 5'd1;
      cfg_q.dilation_rows      <= 5'd1;
      cfg_q.dilation_cols      <= 5'd1;
      cfg_q.input_zero_point   <= 9'sd0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_IMAGE_HEIGHT:  cfg_q.image_height       <= cfg_wdata_i;
        REG_IMAGE_WIDTH:   cfg_q.image_width        <= cfg_wdata_i;
        REG_CHANNELS:      cfg_q.channels_per_group <= cfg_wdata_i;
        REG_KERNEL_HEIGHT: cfg_q.kernel_height      <= cfg_wdata_i[4:0];
        REG_KERNEL_WIDTH:  cfg_q.kernel_width       <= cfg_wdata_i[4:0];
        REG_DILATION_ROWS: cfg_q.dilation_rows      <= cfg_wdata_i[4:0];
        REG_DILATION_COLS: cfg_q.dilation_cols      <= cfg_wdata_i[4:0];
        REG_INPUT_ZP:      cfg_q.input_zero_point   <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  cqm_front #(
    .ActDepth(ActDepth), .WeightDepth(WeightDepth), .MaxOutChannels(MaxOutChannels)
  ) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .store_address_i, .load_value_i,
    .out_channel_i, .group_index_i, .origin_row_i, .origin_col_i,
    .pop_i(pop), .head_o(head)
  );

  cqm_back #(
    .ActDepth(ActDepth), .WeightDepth(WeightDepth), .MaxOutChannels(MaxOutChannels)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .head_i(head), .pop_o(pop),
    .done_o, .conv_sum_o
  );

endmodule

// ===== bench/conv_sum_checker.sv =====
`timescale 1ns / 1ps

module conv_sum_checker import cqm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic [11:0]        store_address_i,
  input  logic signed [8:0]  load_value_i,
  input  logic [5:0]         out_channel_i,
  input  logic [5:0]         group_index_i,
  input  logic signed [8:0]  origin_row_i,
  input  logic signed [8:0]  origin_col_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               done_o,
  input  logic signed [31:0] conv_sum_o,
  output int                 err_count,
  output int                 pending
);

  logic signed [8:0] act_mem [DefActDepth];
  logic signed [8:0] wgt_mem [DefWeightDepth];
  logic signed [8:0] wzp_mem [DefMaxOutChannels];
  cfg_t              shadow_cfg;
  logic [31:0]       sum_queue [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic logic [31:0] conv_window(input logic [5:0] oc, input logic [5:0] grp,
                                              input logic signed [8:0] orow,
                                              input logic signed [8:0] ocol);
    logic [31:0] acc;
    longint      row, col, aaddr, waddr, base, cpg, h, w, kh_n, kw_n;
    int          xv, wv, wzp;
    acc  = '0;
    cpg  = shadow_cfg.channels_per_group;
    h    = shadow_cfg.image_height;
    w    = shadow_cfg.image_width;
    kh_n = shadow_cfg.kernel_height;
    kw_n = shadow_cfg.kernel_width;
    base = longint'(grp) * cpg;
    wzp  = (oc < DefMaxOutChannels) ? int'(wzp_mem[oc]) : 0;
    for (longint c = 0; c < cpg; c++) begin
      for (longint kr = 0; kr < kh_n; kr++) begin
        row = longint'(orow) + kr * shadow_cfg.dilation_rows;
        if (row < 0 || row >= h) continue;
        for (longint kc = 0; kc < kw_n; kc++) begin
          col = longint'(ocol) + kc * shadow_cfg.dilation_cols;
          if (col < 0 || col >= w) continue;
          aaddr = ((base + c) * h + row) * w + col;
          waddr = ((longint'(oc) * cpg + c) * kh_n + kr) * kw_n + kc;
          if (aaddr >= DefActDepth || waddr >= DefWeightDepth) continue;
          xv  = int'(act_mem[aaddr]) - int'(shadow_cfg.input_zero_point);
          wv  = int'(wgt_mem[waddr]) - wzp;
          acc = acc + 32'(xv * wv);
        end
      end
    end
    return acc;
  endfunction

  initial begin
    err_count = 0;
    pending   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg = '{image_height: 9'd1, image_width: 9'd1, channels_per_group: 9'd1,
                     kernel_height: 5'd1, kernel_width: 5'd1, dilation_rows: 5'd1,
                     dilation_cols: 5'd1, input_zero_point: 9'sd0};
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_IMAGE_HEIGHT:  shadow_cfg.image_height       = cfg_wdata_i;
          REG_IMAGE_WIDTH:   shadow_cfg.image_width        = cfg_wdata_i;
          REG_CHANNELS:      shadow_cfg.channels_per_group = cfg_wdata_i;
          REG_KERNEL_HEIGHT: shadow_cfg.kernel_height      = cfg_wdata_i[4:0];
          REG_KERNEL_WIDTH:  shadow_cfg.kernel_width       = cfg_wdata_i[4:0];
          REG_DILATION_ROWS: shadow_cfg.dilation_rows      = cfg_wdata_i[4:0];
          REG_DILATION_COLS: shadow_cfg.dilation_cols      = cfg_wdata_i[4:0];
          REG_INPUT_ZP:      shadow_cfg.input_zero_point   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (done_o) begin
        if (sum_queue.size() == 0) begin
          report("unexpected word", conv_sum_o, '0);
        end else begin
          if (conv_sum_o !== sum_queue[0]) report("conv_sum", conv_sum_o, sum_queue[0]);
          void'(sum_queue.pop_front());
        end
      end
      if (start_i && !busy_o) begin
        case (op_e'(op_i))
          OP_LOAD_ACT: act_mem[store_address_i] = load_value_i;
          OP_LOAD_W:   wgt_mem[store_address_i] = load_value_i;
          OP_LOAD_WZP: begin
            // addresses past the zero point store are dropped
            if (store_address_i < DefMaxOutChannels) wzp_mem[store_address_i] = load_value_i;
          end
          OP_COMPUTE:
            sum_queue.push_back(conv_window(out_channel_i, group_index_i,
                                            origin_row_i, origin_col_i));
          default: ;
        endcase
      end
      pending = sum_queue.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench import cqm_pkg::*;;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         op_i;
  logic [11:0]        store_address_i;
  logic signed [8:0]  load_value_i;
  logic [5:0]         out_channel_i;
  logic [5:0]         group_index_i;
  logic signed [8:0]  origin_row_i;
  logic signed [8:0]  origin_col_i;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               done_o;
  logic signed [31:0] conv_sum_o;
  int                 err_count;
  int                 pending;
  int                 idle_pct;
  int                 cur_h, cur_w, cur_k;

  quantized_conv2d_mac_core u_dut (.*);

  conv_sum_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(input op_e op, input int addr, input int value,
                           input int oc, input int grp, input int orow, input int ocol);
    // each cycle idles with the set chance
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i         = 1'b1;
    op_i            = op;
    store_address_i = 12'(addr);
    load_value_i    = 9'(value);
    out_channel_i   = 6'(oc);
    group_index_i   = 6'(grp);
    origin_row_i    = 9'(orow);
    origin_col_i    = 9'(ocol);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic rand_value(output int v);
    v = int'($urandom_range(383)) - 128;
  endtask

  task automatic write_reg(input reg_e idx, input int value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = CfgW'(value);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // settle the pipe, then rewrite every register
  task automatic set_geometry(input int h, input int w, input int c, input int kh,
                              input int kw, input int dr, input int dc, input int izp);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_CHANNELS, c);
    write_reg(REG_KERNEL_HEIGHT, kh);
    write_reg(REG_KERNEL_WIDTH, kw);
    write_reg(REG_DILATION_ROWS, dr);
    write_reg(REG_DILATION_COLS, dc);
    write_reg(REG_INPUT_ZP, izp);
    cur_h = h;
    cur_w = w;
    cur_k = (kh > kw) ? kh : kw;
  endtask

  task automatic rand_item();
    int v, sel;
    sel = $urandom_range(99);
    rand_value(v);
    if (sel < 12) begin
      send_word(OP_LOAD_ACT, $urandom_range(4095), v, 0, 0, 0, 0);
    end else if (sel < 22) begin
      send_word(OP_LOAD_W, $urandom_range(4095), v, 0, 0, 0, 0);
    end else if (sel < 27) begin
      send_word(OP_LOAD_WZP, $urandom_range(127), v, 0, 0, 0, 0);
    end else if (sel < 33) begin
      send_word(OP_COMPUTE, $urandom_range(4095), v, $urandom_range(63), $urandom_range(63),
                int'($urandom_range(319)) - 64, int'($urandom_range(319)) - 64);
    end else begin
      // windows around the image so most taps land inside
      send_word(OP_COMPUTE, $urandom_range(4095), v, $urandom_range(7), $urandom_range(7),
                int'($urandom_range(cur_h + cur_k)) - cur_k,
                int'($urandom_range(cur_w + cur_k)) - cur_k);
    end
  endtask

  initial begin
    int v;
    start_i = 1'b0; op_i = OP_LOAD_ACT; store_address_i = '0; load_value_i = '0;
    out_channel_i = '0; group_index_i = '0; origin_row_i = '0; origin_col_i = '0;
    cfg_we_i = 1'b0; cfg_idx_i = REG_IMAGE_HEIGHT; cfg_wdata_i = '0;
    idle_pct = 0; cur_h = 1; cur_w = 1; cur_k = 1;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every store entry gets written before any compute
    for (int a = 0; a < DefActDepth; a++) begin
      rand_value(v);
      send_word(OP_LOAD_ACT, a, v, 0, 0, 0, 0);
    end
    for (int a = 0; a < DefWeightDepth; a++) begin
      rand_value(v);
      send_word(OP_LOAD_W, a, v, 0, 0, 0, 0);
    end
    for (int a = 0; a < DefMaxOutChannels; a++) begin
      rand_value(v);
      send_word(OP_LOAD_WZP, a, v, 0, 0, 0, 0);
    end

    // directed corners
    send_word(OP_LOAD_ACT, 0, -128, 0, 0, 0, 0);
    send_word(OP_LOAD_W, 0, 255, 0, 0, 0, 0);
    send_word(OP_LOAD_WZP, 0, -128, 0, 0, 0, 0);
    send_word(OP_LOAD_WZP, 4095, 255, 0, 0, 0, 0);
    send_word(OP_COMPUTE, 0, 0, 0, 0, 0, 0);
    set_geometry(4, 5, 2, 3, 3, 1, 1, 255);
    send_word(OP_COMPUTE, 4095, 255, 63, 63, -64, -64);
    send_word(OP_COMPUTE, 0, -128, 1, 1, -1, -1);
    send_word(OP_COMPUTE, 0, 0, 2, 0, 255, 255);
    send_word(OP_COMPUTE, 0, 0, 3, 2, 2, 3);
    set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_COMPUTE, 0, 0, 5, 1, 0, 0);
    set_geometry(6, 6, 2, 4, 4, 0, 0, -128);
    send_word(OP_COMPUTE, 0, 0, 4, 1, 1, 2);
    send_word(OP_COMPUTE, 0, 0, 4, 1, -1, 5);
    set_geometry(511, 511, 511, 1, 1, 31, 31, 255);
    send_word(OP_COMPUTE, 0, 0, 63, 0, 0, 0);
    send_word(OP_COMPUTE, 0, 0, 0, 63, 255, 255);
    set_geometry(256, 256, 256, 16, 16, 16, 16, -128);
    send_word(OP_COMPUTE, 0, 0, 0, 0, -64, -64);
    set_geometry(40, 40, 1, 31, 31, 1, 1, 7);
    send_word(OP_COMPUTE, 0, 0, 1, 0, 0, 0);
    send_word(OP_COMPUTE, 0, 0, 2, 1, -30, -30);

    for (int pass = 0; pass < 3; pass++) begin
      idle_pct = (pass == 0) ? 37 : (pass == 1) ? 61 : 0;
      for (int ph = 0; ph < 6; ph++) begin
        set_geometry($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 4),
                     $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(0, 3),
                     $urandom_range(0, 3), int'($urandom_range(383)) - 128);
        for (int n = 0; n < 100; n++) rand_item();
      end
    end

    start_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
